@@ src/jtm_pkg.sv @@
// jtm_pkg: shared constants, tables and item types for the joystick to mecanum mixer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jtm_pkg;

    localparam int UW        = 17;   // stick offset, signed
    localparam int VW        = 35;   // vectoring datapath, signed
    localparam int RW        = 33;   // rotation datapath, signed
    localparam int DIV_STEPS = 15;   // deflection quotient bits
    localparam int QW        = 17;   // drive quotient bits
    localparam int MAX_STEPS = 24;

    localparam logic [15:0] Q_ONE      = 16'd32768;
    localparam logic [14:0] FULL_TURN  = 15'd23040;
    localparam logic [14:0] HALF_TURN  = 15'd11520;
    localparam logic [14:0] QUART_TURN = 15'd5760;
    localparam logic [14:0] TQ_TURN    = 15'd17280;
    localparam logic [31:0] ANG_45     = 32'h2000_0000;
    localparam logic [31:0] ANG_180    = 32'h8000_0000;
    localparam int          PhiDiv     = 45;
    localparam logic [10:0] RECIP_45   = 11'd1456;

    localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef logic [22:0] phi_tab_t [PhiDiv];

    // fractional part of round(h * 2^32 / 23040) for h mod 45
    function automatic phi_tab_t make_phi_tab();
        phi_tab_t t;
        longint   v;
        for (int r = 0; r < PhiDiv; r++) begin
            v    = (longint'(r) * 64'd8388608 + 64'd22) / PhiDiv;
            t[r] = v[22:0];
        end
        return t;
    endfunction

    localparam phi_tab_t PHI_TAB = make_phi_tab();

    typedef enum logic [1:0] {
        REG_CENTER = 2'd0,
        REG_SNAP   = 2'd1,
        REG_INNER  = 2'd2,
        REG_OUTER  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [14:0] center;
        logic [11:0] snap;
        logic [14:0] inner;
        logic [14:0] outer;
    } cfg_t;

    typedef struct packed {
        logic [14:0] heading;
        logic [15:0] defl;
    } hp_t;

    typedef struct packed {
        logic [14:0] heading;
        logic [15:0] defl;
        logic [2:0]  oct;
        logic [29:0] g;
    } shp_t;

endpackage

`default_nettype wire

@@ src/jtm_heading.sv @@
// jtm_heading: input stage, pipelined vectoring CORDIC for heading and
// pipelined restoring divider for raw deflection. Depends on jtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtm_heading #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire jtm_pkg::cfg_t cfg,
    input  wire logic         vld_in,
    input  wire logic [15:0]  x_raw,
    input  wire logic [15:0]  y_raw,
    output logic              vld_out,
    output jtm_pkg::hp_t      res
);

    localparam int L  = (CORDIC_STEPS > jtm_pkg::DIV_STEPS) ? CORDIC_STEPS
                                                            : jtm_pkg::DIV_STEPS;
    localparam int VW = jtm_pkg::VW;
    localparam int UW = jtm_pkg::UW;

    typedef struct packed {
        logic oor;
        logic zero;
        logic big;
    } hdg_side_t;

    logic [14:0]           c_eff;
    logic [16:0]           lim;
    logic [15:0]           xs, ys;
    logic signed [UW-1:0]  ux, uy;
    logic [16:0]           ax, ay, mag;
    logic signed [VW-1:0]  vx, vy;
    hdg_side_t             side0;

    assign c_eff = (cfg.center == 15'd0) ? 15'd1 : cfg.center;
    assign lim   = {1'b0, c_eff, 1'b1};
    assign xs    = 16'(x_raw[SAMPLE_BITS-1:0]);
    assign ys    = 16'(y_raw[SAMPLE_BITS-1:0]);
    assign ux    = $signed({1'b0, xs}) - $signed({2'b00, c_eff});
    assign uy    = $signed({2'b00, c_eff}) - $signed({1'b0, ys});
    assign ax    = ux[UW-1] ? 17'(-ux) : 17'(ux);
    assign ay    = uy[UW-1] ? 17'(-uy) : 17'(uy);
    assign mag   = (ax > ay) ? ax : ay;
    assign vx    = VW'(ux) <<< 16;
    assign vy    = VW'(uy) <<< 16;

    assign side0.oor  = ({1'b0, xs} > lim) || ({1'b0, ys} > lim);
    assign side0.zero = (ux == '0) && (uy == '0);
    assign side0.big  = mag >= {2'b00, c_eff};

    logic                 vld_reg  [L+1];
    hdg_side_t            side_reg [L+1];
    logic signed [VW-1:0] cx_reg   [L+1];
    logic signed [VW-1:0] cy_reg   [L+1];
    logic [31:0]          acc_reg  [L+1];
    logic [14:0]          rem_reg  [L+1];
    logic [14:0]          q_reg    [L+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side0;
            rem_reg[0]  <= mag[14:0];
            q_reg[0]    <= '0;
            if (ux[UW-1])
            begin
                cx_reg[0]  <= -vx;
                cy_reg[0]  <= -vy;
                acc_reg[0] <= jtm_pkg::ANG_180;
            end
            else
            begin
                cx_reg[0]  <= vx;
                cy_reg[0]  <= vy;
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < L; i++)
    begin : g_stage
        logic signed [VW-1:0] x_n, y_n;
        logic [31:0]          acc_n;
        logic [14:0]          rem_n, q_n;

        if (i < CORDIC_STEPS)
        begin : g_cordic
            always_comb
            begin
                if (!cy_reg[i][VW-1])
                begin
                    x_n   = cx_reg[i] + (cy_reg[i] >>> i);
                    y_n   = cy_reg[i] - (cx_reg[i] >>> i);
                    acc_n = acc_reg[i] + jtm_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_n   = cx_reg[i] - (cy_reg[i] >>> i);
                    y_n   = cy_reg[i] + (cx_reg[i] >>> i);
                    acc_n = acc_reg[i] - jtm_pkg::ATAN_TAB[i];
                end
            end
        end
        else
        begin : g_cpass
            assign x_n   = cx_reg[i];
            assign y_n   = cy_reg[i];
            assign acc_n = acc_reg[i];
        end

        if (i < jtm_pkg::DIV_STEPS)
        begin : g_div
            logic [15:0] t;
            logic        ge;
            assign t     = {rem_reg[i], 1'b0};
            assign ge    = t >= {1'b0, c_eff};
            assign rem_n = ge ? 15'(t - {1'b0, c_eff}) : t[14:0];
            assign q_n   = {q_reg[i][13:0], ge};
        end
        else
        begin : g_dpass
            assign rem_n = rem_reg[i];
            assign q_n   = q_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                cx_reg[i+1]   <= x_n;
                cy_reg[i+1]   <= y_n;
                acc_reg[i+1]  <= acc_n;
                rem_reg[i+1]  <= rem_n;
                q_reg[i+1]    <= q_n;
            end
        end
    end

    // heading scale and deflection select
    logic        vm_reg;
    hdg_side_t   sm_reg;
    logic [46:0] prod_reg;
    logic [15:0] pm_reg;
    logic [47:0] hsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg  <= 1'b0;
            vld_out <= 1'b0;
        end
        else if (en)
        begin
            vm_reg  <= vld_reg[L];
            vld_out <= vm_reg;
        end
    end

    assign hsum = {1'b0, prod_reg} + 48'h0000_8000_0000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_reg   <= side_reg[L];
            prod_reg <= 47'(acc_reg[L]) * 47'(jtm_pkg::FULL_TURN);
            pm_reg   <= (side_reg[L].oor || side_reg[L].big) ? jtm_pkg::Q_ONE
                                                             : {1'b0, q_reg[L]};
            res.defl <= pm_reg;
            if (sm_reg.oor)
            begin
                res.heading <= '0;
            end
            else if (sm_reg.zero)
            begin
                res.heading <= jtm_pkg::HALF_TURN;
            end
            else
            begin
                res.heading <= hsum[46:32];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/jtm_shape.sv @@
// jtm_shape: axis snap, dead zones and heading to octant angle conversion.
// Four register stages. Depends on jtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtm_shape (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire jtm_pkg::cfg_t cfg,
    input  wire logic          vld_in,
    input  wire jtm_pkg::hp_t  item,
    output logic               vld_out,
    output jtm_pkg::shp_t      res
);

    logic [15:0] h, r;
    logic [16:0] p, full_lvl;
    logic [14:0] h_snap;
    logic [15:0] p_dz;

    assign h        = {1'b0, item.heading};
    assign r        = {4'b0, cfg.snap};
    assign p        = {1'b0, item.defl};
    assign full_lvl = 17'(jtm_pkg::Q_ONE) - {2'b00, cfg.outer};

    always_comb
    begin
        h_snap = item.heading;
        if (h <= r || h >= {1'b0, jtm_pkg::FULL_TURN} - r)
        begin
            h_snap = '0;
        end
        else if (h >= {1'b0, jtm_pkg::QUART_TURN} - r && h <= {1'b0, jtm_pkg::QUART_TURN} + r)
        begin
            h_snap = jtm_pkg::QUART_TURN;
        end
        else if (h >= {1'b0, jtm_pkg::HALF_TURN} - r && h <= {1'b0, jtm_pkg::HALF_TURN} + r)
        begin
            h_snap = jtm_pkg::HALF_TURN;
        end
        else if (h >= {1'b0, jtm_pkg::TQ_TURN} - r && h <= {1'b0, jtm_pkg::TQ_TURN} + r)
        begin
            h_snap = jtm_pkg::TQ_TURN;
        end
    end

    always_comb
    begin
        p_dz = item.defl;
        if (p <= {2'b00, cfg.inner})
        begin
            p_dz = '0;
        end
        else if (p >= full_lvl)
        begin
            p_dz = jtm_pkg::Q_ONE;
        end
    end

    logic        va_reg, vb_reg, vc_reg;
    logic [14:0] ha_reg, hb_reg, hc_reg;
    logic [15:0] pa_reg, pb_reg, pc_reg;
    logic [9:0]  qb_reg;
    logic [31:0] phi_reg;

    logic [25:0] qprod;
    logic [15:0] m45;
    logic [6:0]  r0;
    logic        corr;
    logic [9:0]  q;
    logic [5:0]  ridx;
    logic [31:0] phi_n;
    logic [2:0]  oct;
    logic [28:0] frac;

    assign qprod = 26'(ha_reg) * 26'(jtm_pkg::RECIP_45);
    assign m45   = 16'(qb_reg) * 16'(jtm_pkg::PhiDiv);
    assign r0    = 7'({1'b0, hb_reg} - m45);
    assign corr  = r0 >= 7'(jtm_pkg::PhiDiv);
    assign q     = qb_reg + 10'(corr);
    assign ridx  = corr ? 6'(r0 - 7'(jtm_pkg::PhiDiv)) : r0[5:0];
    assign phi_n = {q[8:0], 23'b0} + {9'b0, jtm_pkg::PHI_TAB[ridx]} - jtm_pkg::ANG_45;
    assign oct   = phi_reg[31:29];
    assign frac  = phi_reg[28:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            vld_out <= 1'b0;
        end
        else if (en)
        begin
            va_reg  <= vld_in;
            vb_reg  <= va_reg;
            vc_reg  <= vb_reg;
            vld_out <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ha_reg      <= h_snap;
            pa_reg      <= p_dz;
            hb_reg      <= ha_reg;
            pb_reg      <= pa_reg;
            qb_reg      <= qprod[25:16];
            hc_reg      <= hb_reg;
            pc_reg      <= pb_reg;
            phi_reg     <= phi_n;
            res.heading <= hc_reg;
            res.defl    <= pc_reg;
            res.oct     <= oct;
            res.g       <= oct[0] ? 30'(jtm_pkg::ANG_45) - {1'b0, frac} : {1'b0, frac};
        end
    end

endmodule

`default_nettype wire

@@ src/jtm_drive.sv @@
// jtm_drive: rotation CORDIC for the octant tangent, scale by deflection,
// pipelined divider and sign/swap into the two wheel groups. Depends on jtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtm_drive #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire jtm_pkg::shp_t item,
    output logic               vld_out,
    output logic [14:0]        heading,
    output logic [15:0]        deflection,
    output logic signed [16:0] motor_a,
    output logic signed [16:0] motor_b
);

    localparam int N  = CORDIC_STEPS;
    localparam int RW = jtm_pkg::RW;
    localparam int QW = jtm_pkg::QW;

    typedef struct packed {
        jtm_pkg::shp_t it;
        logic          gz;
        logic          gfull;
    } drv_side_t;

    logic                 vld_reg  [N+1];
    drv_side_t            side_reg [N+1];
    logic signed [RW-1:0] rx_reg   [N+1];
    logic signed [RW-1:0] ry_reg   [N+1];
    logic signed [31:0]   rz_reg   [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].it    <= item;
            side_reg[0].gz    <= item.g == '0;
            side_reg[0].gfull <= {2'b00, item.g} >= jtm_pkg::ANG_45;
            rx_reg[0]         <= RW'(34'sh0_4000_0000);
            ry_reg[0]         <= '0;
            rz_reg[0]         <= $signed({2'b00, item.g});
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        logic signed [RW-1:0] x_n, y_n;
        logic signed [31:0]   z_n;

        always_comb
        begin
            if (!rz_reg[i][31])
            begin
                x_n = rx_reg[i] - (ry_reg[i] >>> i);
                y_n = ry_reg[i] + (rx_reg[i] >>> i);
                z_n = rz_reg[i] - $signed(jtm_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x_n = rx_reg[i] + (ry_reg[i] >>> i);
                y_n = ry_reg[i] - (rx_reg[i] >>> i);
                z_n = rz_reg[i] + $signed(jtm_pkg::ATAN_TAB[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                rx_reg[i+1]   <= x_n;
                ry_reg[i+1]   <= y_n;
                rz_reg[i+1]   <= z_n;
            end
        end
    end

    // p * y, then + x/2
    logic        vm_reg, va_reg;
    drv_side_t   sm_reg, sa_reg;
    logic        ypos_m_reg, xpos_m_reg, ypos_a_reg, xpos_a_reg;
    logic [47:0] prod_reg;
    logic [31:0] xm_reg, xa_reg;
    logic [47:0] num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= vld_reg[N];
            va_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_reg     <= side_reg[N];
            ypos_m_reg <= !ry_reg[N][RW-1] && (ry_reg[N] != '0);
            xpos_m_reg <= !rx_reg[N][RW-1] && (rx_reg[N] != '0);
            prod_reg   <= 48'(side_reg[N].it.defl) * 48'(ry_reg[N][31:0]);
            xm_reg     <= rx_reg[N][31:0];
            sa_reg     <= sm_reg;
            ypos_a_reg <= ypos_m_reg;
            xpos_a_reg <= xpos_m_reg;
            num_reg    <= prod_reg + 48'(xm_reg >> 1);
            xa_reg     <= xm_reg;
        end
    end

    logic        dv_reg   [QW+1];
    drv_side_t   ds_reg   [QW+1];
    logic        dyp_reg  [QW+1];
    logic        dxp_reg  [QW+1];
    logic [31:0] dx_reg   [QW+1];
    logic [31:0] drem_reg [QW+1];
    logic [QW-1:0] dlow_reg [QW+1];
    logic [QW-1:0] dq_reg   [QW+1];

    always_comb
    begin
        dv_reg[0]   = va_reg;
        ds_reg[0]   = sa_reg;
        dyp_reg[0]  = ypos_a_reg;
        dxp_reg[0]  = xpos_a_reg;
        dx_reg[0]   = xa_reg;
        drem_reg[0] = {1'b0, num_reg[47:QW]};
        dlow_reg[0] = num_reg[QW-1:0];
        dq_reg[0]   = '0;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [32:0] t;
        logic        ge;

        assign t  = {drem_reg[k], dlow_reg[k][QW-1]};
        assign ge = t >= {1'b0, dx_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ds_reg[k+1]   <= ds_reg[k];
                dyp_reg[k+1]  <= dyp_reg[k];
                dxp_reg[k+1]  <= dxp_reg[k];
                dx_reg[k+1]   <= dx_reg[k];
                drem_reg[k+1] <= ge ? 32'(t - {1'b0, dx_reg[k]}) : t[31:0];
                dlow_reg[k+1] <= {dlow_reg[k][QW-2:0], 1'b0};
                dq_reg[k+1]   <= {dq_reg[k][QW-2:0], ge};
            end
        end
    end

    drv_side_t   fs;
    logic [15:0] p, mn;
    logic        major_a, cos_neg, sin_neg;
    logic [15:0] va, vb;

    assign fs      = ds_reg[QW];
    assign p       = fs.it.defl;
    assign major_a = !(fs.it.oct[0] ^ fs.it.oct[1]);
    assign cos_neg = fs.it.oct[1] ^ fs.it.oct[2];
    assign sin_neg = fs.it.oct[2];

    always_comb
    begin
        if (fs.gz)
        begin
            mn = '0;
        end
        else if (fs.gfull)
        begin
            mn = p;
        end
        else if (!dyp_reg[QW])
        begin
            mn = '0;
        end
        else if (!dxp_reg[QW])
        begin
            mn = p;
        end
        else if (dq_reg[QW] > {1'b0, p})
        begin
            mn = p;
        end
        else
        begin
            mn = dq_reg[QW][15:0];
        end
    end

    assign va = major_a ? p : mn;
    assign vb = major_a ? mn : p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out <= 1'b0;
        end
        else if (en)
        begin
            vld_out <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            heading    <= fs.it.heading;
            deflection <= p;
            motor_a    <= cos_neg ? -$signed({1'b0, va}) : $signed({1'b0, va});
            motor_b    <= sin_neg ? -$signed({1'b0, vb}) : $signed({1'b0, vb});
        end
    end

endmodule

`default_nettype wire

@@ src/joystick_to_mecanum_mixer.sv @@
// joystick_to_mecanum_mixer: top level with configuration registers and handshake.
// Instantiates jtm_heading, jtm_shape and jtm_drive; depends on jtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Converts one joystick x/y request into a snapped heading (1/64 degree), a
// dead-zoned deflection (Q1.15) and two mecanum wheel-group drives. Fully
// pipelined: one request per clock while out_stall does not hold it; the
// requests pass through the vectoring CORDIC/deflection divider, the
// rotation CORDIC and the 17-step drive divider. The whole pipeline holds
// while a result waits with out_stall high; the last stage is the output
// register. Write configuration only while no request is in flight.

module joystick_to_mecanum_mixer #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [14:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        x_raw,
    input  wire logic [15:0]        y_raw,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [14:0]             heading,
    output logic [15:0]             deflection,
    output logic signed [16:0]      motor_a,
    output logic signed [16:0]      motor_b
);

    jtm_pkg::cfg_t cfg_reg;
    logic          en;
    logic          hv, sv;
    jtm_pkg::hp_t  hp;
    jtm_pkg::shp_t sp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center <= 15'd2047;
            cfg_reg.snap   <= 12'd192;
            cfg_reg.inner  <= 15'd1638;
            cfg_reg.outer  <= 15'd1638;
        end
        else if (cfg_we)
        begin
            unique case (jtm_pkg::reg_idx_t'(cfg_index))
                jtm_pkg::REG_CENTER: cfg_reg.center <= cfg_data;
                jtm_pkg::REG_SNAP:   cfg_reg.snap   <= cfg_data[11:0];
                jtm_pkg::REG_INNER:  cfg_reg.inner  <= cfg_data;
                jtm_pkg::REG_OUTER:  cfg_reg.outer  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    jtm_heading #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_heading (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .vld_in  (in_valid),
        .x_raw   (x_raw),
        .y_raw   (y_raw),
        .vld_out (hv),
        .res     (hp)
    );

    jtm_shape u_shape (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .vld_in  (hv),
        .item    (hp),
        .vld_out (sv),
        .res     (sp)
    );

    jtm_drive #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .vld_in     (sv),
        .item       (sp),
        .vld_out    (out_valid),
        .heading    (heading),
        .deflection (deflection),
        .motor_a    (motor_a),
        .motor_b    (motor_b)
    );

`ifndef SYNTHESIS
    a_defl_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> deflection <= jtm_pkg::Q_ONE)
        else $error("deflection above full scale");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading < jtm_pkg::FULL_TURN)
        else $error("heading out of range");

    a_major_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_a == $signed({1'b0, deflection})
                    || motor_a == -$signed({1'b0, deflection})
                    || motor_b == $signed({1'b0, deflection})
                    || motor_b == -$signed({1'b0, deflection})))
        else $error("no wheel group carries the full deflection");

    a_zero_defl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && deflection == '0) |-> (motor_a == '0 && motor_b == '0))
        else $error("drive without deflection");
`endif

endmodule

`default_nettype wire

@@ test/joystick_to_mecanum_mixer_tb.sv @@
// joystick_to_mecanum_mixer_tb: self-checking bench for the joystick to mecanum mixer.
// Drives directed and random stick samples under several register settings; checks
// each result against a typed value or a built-in predictor. Uses jtm_pkg, mixer RTL.
`timescale 1ns / 1ps

module joystick_to_mecanum_mixer_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct {
        logic [14:0]        heading;
        logic [15:0]        defl;
        logic signed [16:0] mot_a;
        logic signed [16:0] mot_b;
    } drive_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        bit          typed;
        drive_t      res;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [14:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        x_raw;
    logic [15:0]        y_raw;
    logic               out_valid;
    logic               out_stall;
    logic [14:0]        heading;
    logic [15:0]        deflection;
    logic signed [16:0] motor_a;
    logic signed [16:0] motor_b;

    joystick_to_mecanum_mixer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_raw      (x_raw),
        .y_raw      (y_raw),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .heading    (heading),
        .deflection (deflection),
        .motor_a    (motor_a),
        .motor_b    (motor_b)
    );

    longint mdl_center = 2047;
    longint mdl_snap   = 192;
    longint mdl_inner  = 1638;
    longint mdl_outer  = 1638;

    drive_t drive_q[$];
    int     err_cnt   = 0;
    int     idle_cnt  = 0;
    int     in_gap_pct = 30;
    int     out_stall_pct = 30;

    function automatic longint stick_angle(longint ux, longint uy);
        longint     vx, vy, dx, dy;
        bit [31:0]  acc;
        bit [63:0]  prod;
        vx  = ux * 65536;
        vy  = uy * 65536;
        acc = 32'h0;
        if (vx < 0)
        begin
            vx  = -vx;
            vy  = -vy;
            acc = jtm_pkg::ANG_180;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + jtm_pkg::ATAN_TAB[i];
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - jtm_pkg::ATAN_TAB[i];
            end
        end
        prod = 64'(acc) * 64'd23040 + 64'h8000_0000;
        return longint'(prod >> 32);
    endfunction

    function automatic longint minor_share(longint p, longint g);
        longint rx, ry, rz, dx, dy, m;
        rx = longint'(1) <<< 30;
        ry = 0;
        rz = g;
        if (g <= 0)
            return 0;
        if (g >= 64'sh2000_0000)
            return p;
        for (int i = 0; i < 16; i++)
        begin
            dx = ry >>> i;
            dy = rx >>> i;
            if (rz >= 0)
            begin
                rx = rx - dx;
                ry = ry + dy;
                rz = rz - longint'(jtm_pkg::ATAN_TAB[i]);
            end
            else
            begin
                rx = rx + dx;
                ry = ry - dy;
                rz = rz + longint'(jtm_pkg::ATAN_TAB[i]);
            end
        end
        if (ry <= 0)
            return 0;
        if (rx <= 0)
            return p;
        m = (p * ry + rx / 2) / rx;
        return (m > p) ? p : m;
    endfunction

    function automatic drive_t mix_predict(logic [15:0] xs, logic [15:0] ys);
        bit       major_a [8] = '{1, 0, 0, 1, 1, 0, 0, 1};
        int       csign   [8] = '{1, 1, -1, -1, -1, -1, 1, 1};
        int       ssign   [8] = '{1, 1, 1, 1, -1, -1, -1, -1};
        longint   c, lim, x, y, ux, uy, ax, ay, m, h, p, r, g, mn, a, b;
        bit [63:0] phi64;
        bit [31:0] phi;
        int       oct;
        drive_t   res;
        c   = (mdl_center != 0) ? mdl_center : 1;
        lim = 2 * c + 1;
        x   = longint'(xs);
        y   = longint'(ys);
        r   = mdl_snap;
        if (x > lim || y > lim)
        begin
            h = 0;
            p = 32768;
        end
        else
        begin
            ux = x - c;
            uy = c - y;
            ax = (ux < 0) ? -ux : ux;
            ay = (uy < 0) ? -uy : uy;
            m  = (ax > ay) ? ax : ay;
            h  = (ux == 0 && uy == 0) ? 11520 : stick_angle(ux, uy);
            p  = m * 32768 / c;
            if (p > 32768)
                p = 32768;
        end
        if (h <= r || h >= 23040 - r)
            h = 0;
        else if (h >= 5760 - r && h <= 5760 + r)
            h = 5760;
        else if (h >= 11520 - r && h <= 11520 + r)
            h = 11520;
        else if (h >= 17280 - r && h <= 17280 + r)
            h = 17280;
        if (p <= mdl_inner)
            p = 0;
        else if (p >= 32768 - mdl_outer)
            p = 32768;
        phi64 = ((64'(h) << 32) + 64'd11520) / 64'd23040;
        phi   = phi64[31:0] - jtm_pkg::ANG_45;
        oct   = int'(phi[31:29]);
        g     = (oct % 2 == 1) ? (longint'(jtm_pkg::ANG_45) - longint'(phi[28:0]))
                               : longint'(phi[28:0]);
        mn    = minor_share(p, g);
        if (major_a[oct])
        begin
            a = csign[oct] * p;
            b = ssign[oct] * mn;
        end
        else
        begin
            a = csign[oct] * mn;
            b = ssign[oct] * p;
        end
        if (a > 32768) a = 32768;
        if (a < -32768) a = -32768;
        if (b > 32768) b = 32768;
        if (b < -32768) b = -32768;
        res.heading = h[14:0];
        res.defl    = p[15:0];
        res.mot_a   = a[16:0];
        res.mot_b   = b[16:0];
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // output side: out_stall set at random, high with chance out_stall_pct percent
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                @(negedge clk);
                out_stall <= ($urandom_range(0, 99) < out_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        drive_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                $display("%0t: unexpected result h=%0d p=%0d a=%0d b=%0d",
                         $time, heading, deflection, motor_a, motor_b);
                err_cnt++;
            end
            else
            begin
                want = drive_q.pop_front();
                if (heading !== want.heading)
                begin
                    $display("%0t: heading expected %0d actual %0d", $time, want.heading, heading);
                    err_cnt++;
                end
                if (deflection !== want.defl)
                begin
                    $display("%0t: deflection expected %0d actual %0d",
                             $time, want.defl, deflection);
                    err_cnt++;
                end
                if (motor_a !== want.mot_a)
                begin
                    $display("%0t: motor_a expected %0d actual %0d", $time, want.mot_a, motor_a);
                    err_cnt++;
                end
                if (motor_b !== want.mot_b)
                begin
                    $display("%0t: motor_b expected %0d actual %0d", $time, want.mot_b, motor_b);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("[joystick_to_mecanum_mixer] ERROR");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] xs, logic [15:0] ys, bit typed, drive_t res);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < in_gap_pct)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        for (int i = 0; i < gap; i++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            x_raw    <= 16'($urandom);
            y_raw    <= 16'($urandom);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        x_raw    <= xs;
        y_raw    <= ys;
        do
            @(posedge clk);
        while (in_stall);
        drive_q.push_back(typed ? res : mix_predict(xs, ys));
    endtask

    task automatic set_registers(longint cv, longint sv, longint iv, longint ov);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (drive_q.size() == 0);
        repeat (80) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= jtm_pkg::REG_CENTER;
        cfg_data  <= cv[14:0];
        @(negedge clk);
        cfg_index <= jtm_pkg::REG_SNAP;
        cfg_data  <= sv[14:0];
        @(negedge clk);
        cfg_index <= jtm_pkg::REG_INNER;
        cfg_data  <= iv[14:0];
        @(negedge clk);
        cfg_index <= jtm_pkg::REG_OUTER;
        cfg_data  <= ov[14:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        mdl_center = cv & 32'h7FFF;
        mdl_snap   = sv & 32'hFFF;
        mdl_inner  = iv & 32'h7FFF;
        mdl_outer  = ov & 32'h7FFF;
    endtask

    initial
    begin
        stim_row_t rows[$];
        drive_t    none;
        longint    c, lim, xs, ys, d;
        int        kind;
        none = '{default: 0};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = jtm_pkg::REG_CENTER;
        cfg_data  = '0;
        in_valid  = 1'b0;
        x_raw     = '0;
        y_raw     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: center 2047, snap 192, dead zones 1638
        rows.push_back('{16'd2047, 16'd2047, 1, '{15'd11520, 16'd0, 17'sd0, 17'sd0}});
        rows.push_back('{16'hFFFF, 16'd0, 1, '{15'd0, 16'd32768, 17'sd32768, -17'sd32768}});
        rows.push_back('{16'd0, 16'hFFFF, 1, '{15'd0, 16'd32768, 17'sd32768, -17'sd32768}});
        rows.push_back('{16'hFFFF, 16'hFFFF, 1, '{15'd0, 16'd32768, 17'sd32768, -17'sd32768}});
        rows.push_back('{16'd4096, 16'd2047, 1, '{15'd0, 16'd32768, 17'sd32768, -17'sd32768}});
        rows.push_back('{16'd0, 16'd0, 0, none});
        rows.push_back('{16'd4094, 16'd0, 0, none});
        rows.push_back('{16'd0, 16'd4094, 0, none});
        rows.push_back('{16'd4094, 16'd4094, 0, none});
        rows.push_back('{16'd4095, 16'd4095, 0, none});
        rows.push_back('{16'd4095, 16'd2047, 0, none});
        rows.push_back('{16'd0, 16'd2047, 0, none});
        rows.push_back('{16'd2047, 16'd0, 0, none});
        rows.push_back('{16'd2047, 16'd4095, 0, none});
        rows.push_back('{16'd2048, 16'd2047, 0, none});
        rows.push_back('{16'd3500, 16'd2047 - 16'd40, 0, none});
        rows.push_back('{16'd3500, 16'd2047 + 16'd40, 0, none});
        rows.push_back('{16'd2047 + 16'd220, 16'd2047, 0, none});
        rows.push_back('{16'd2047 + 16'd400, 16'd2047 - 16'd400, 0, none});
        rows.push_back('{16'd2047 - 16'd900, 16'd2047 + 16'd900, 0, none});
        rows.push_back('{16'd2047 + 16'd1900, 16'd2047 - 16'd300, 0, none});
        rows.push_back('{16'd2047 - 16'd100, 16'd2047 - 16'd1800, 0, none});
        foreach (rows[i])
            send_sample(rows[i].x, rows[i].y, rows[i].typed, rows[i].res);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: ;
                1: set_registers(0, 0, 0, 0);
                2: set_registers(32767, 2880, 16384, 16384);
                3: set_registers(1, 4095, 16384, 0);
                4: set_registers(32767, 0, 0, 0);
                default: set_registers($urandom_range(1, 32767), $urandom_range(0, 2880),
                                       $urandom_range(0, 16384), $urandom_range(0, 16384));
            endcase
            in_gap_pct    = (ph % 3 == 2) ? 0 : $urandom_range(5, 60);
            out_stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 60);
            c   = (mdl_center != 0) ? mdl_center : 1;
            lim = 2 * c + 1;
            if (lim > 65535)
                lim = 65535;
            for (int n = 0; n < 150; n++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    xs = $urandom_range(0, int'(lim));
                    ys = $urandom_range(0, int'(lim));
                end
                else if (kind < 8)
                begin
                    d  = $urandom_range(0, 8);
                    xs = c + $urandom_range(0, int'(d)) - d / 2;
                    ys = ($urandom_range(0, 1) == 1) ? $urandom_range(0, int'(lim))
                                                     : c + $urandom_range(0, 6) - 3;
                    if (xs < 0) xs = 0;
                    if (ys < 0) ys = 0;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        d  = xs;
                        xs = ys;
                        ys = d;
                    end
                end
                else
                begin
                    xs = $urandom_range(0, 65535);
                    ys = $urandom_range(0, 65535);
                end
                send_sample(xs[15:0], ys[15:0], 0, none);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (drive_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("[joystick_to_mecanum_mixer] OK");
        else
            $display("[joystick_to_mecanum_mixer] ERROR");
        $finish;
    end

endmodule
